### hw/rtl/clint_pkg.sv
// shared types and constants for the core-local timer interruptor
`timescale 1ns / 1ps

package clint_pkg;

  // command codes
  localparam logic [1:0] CMD_READ  = 2'd0;
  localparam logic [1:0] CMD_WRITE = 2'd1;
  localparam logic [1:0] CMD_TICK  = 2'd2;
  localparam logic [1:0] CMD_RESET = 2'd3;

  // fault codes
  localparam logic [1:0] FAULT_NONE  = 2'd0;
  localparam logic [1:0] FAULT_LOAD  = 2'd1;
  localparam logic [1:0] FAULT_STORE = 2'd2;

  // configuration register indexes
  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] REG_ACTIVE_HARTS   = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_TICK_INCREMENT = 1'b1;
  localparam int CFG_DATA_W = 32;

  // address map
  localparam logic [15:0] CMP_BASE  = 16'h4000;
  localparam logic [15:0] TIME_LO   = 16'hBFF8;
  localparam logic [15:0] TIME_HI   = 16'hBFFC;
  localparam logic [3:0]  WORD_SIZE = 4'd4;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [15:0] offset;
    logic [3:0]  access_size;
    logic [31:0] write_data;
  } in_t;

  typedef struct packed {
    logic [31:0] read_data;
    logic [1:0]  fault_code;
    logic [3:0]  timer_pending;
    logic [3:0]  soft_pending;
    logic [3:0]  wake_mask;
  } out_t;

  // controller to datapath commands
  typedef struct packed {
    logic load;
    logic exec;
    logic eval;
  } ctl_t;

endpackage

### hw/rtl/clint_ctrl.sv
// controller state machine for the core-local timer interruptor
`timescale 1ns / 1ps

module clint_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  output logic            busy,
  output logic            done,
  output clint_pkg::ctl_t ctl
);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_EXEC = 3'b010,
    ST_EVAL = 3'b100
  } state_t;

  state_t state;
  state_t state_next;

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (start) state_next = ST_EXEC;
      end
      ST_EXEC: state_next = ST_EVAL;
      ST_EVAL: state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      done  <= (state == ST_EVAL);
    end
  end

  assign busy     = (state != ST_IDLE);
  assign ctl.load = (state == ST_IDLE) && start;
  assign ctl.exec = (state == ST_EXEC);
  assign ctl.eval = (state == ST_EVAL);

endmodule

### hw/rtl/clint_dp.sv
// datapath: time counter, compare values, soft bits and timer bits
`timescale 1ns / 1ps

module clint_dp #(
  parameter int HART_COUNT = 4
) (
  input  logic                               clk,
  input  logic                               rst,
  input  clint_pkg::ctl_t                    ctl,
  input  clint_pkg::in_t                     item,
  input  logic                               cfg_we,
  input  logic [clint_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [clint_pkg::CFG_DATA_W-1:0]   cfg_data,
  output clint_pkg::out_t                    result
);

  localparam int HW = (HART_COUNT > 1) ? $clog2(HART_COUNT) : 1;

  // architectural state
  logic [63:0]           time_count;
  logic [63:0]           cmp [HART_COUNT];
  logic [HART_COUNT-1:0] soft_bits;
  logic [HART_COUNT-1:0] timer;
  logic [2:0]            active_harts;
  logic [31:0]           tick_increment;

  // item and intermediate payload
  clint_pkg::in_t        item_q;
  logic [31:0]           rd_q;
  logic [1:0]            fault_q;
  logic [HART_COUNT-1:0] recmask;
  logic [HART_COUNT-1:0] wake_q;

  // decode
  logic [15:0]           live;
  logic [HART_COUNT-1:0] live_mask;
  logic [15:0]           bo;
  logic [15:0]           idx_s;
  logic [15:0]           idx_c;
  logic                  is_msip;
  logic                  is_cmp;
  logic                  is_time;
  logic                  hi;
  logic                  acc_ok;
  logic [HW-1:0]         hsel;
  logic [HART_COUNT-1:0] hsel_mask;
  logic [31:0]           rdata;
  logic [63:0]           cmp_sel;

  // recompute
  logic [HART_COUNT-1:0] ge;
  logic [HART_COUNT-1:0] tnext;
  logic [HART_COUNT-1:0] wake_all;
  logic [HART_COUNT+3:0] tp_ext;
  logic [HART_COUNT+3:0] sp_ext;
  logic [HART_COUNT+3:0] wk_ext;

  always_comb begin
    live = ({13'd0, active_harts} > 16'(HART_COUNT)) ? 16'(HART_COUNT)
                                                     : {13'd0, active_harts};
    for (int h = 0; h < HART_COUNT; h++) begin
      live_mask[h] = (16'(h) < live);
    end
    bo      = item_q.offset - clint_pkg::CMP_BASE;
    idx_s   = {2'd0, item_q.offset[15:2]};
    idx_c   = {3'd0, bo[15:3]};
    is_msip = (item_q.offset < clint_pkg::CMP_BASE);
    is_cmp  = !is_msip && (item_q.offset < clint_pkg::TIME_LO);
    is_time = (item_q.offset == clint_pkg::TIME_LO) ||
              (item_q.offset == clint_pkg::TIME_HI);
    hi      = item_q.offset[2];
    hsel    = is_msip ? idx_s[HW-1:0] : idx_c[HW-1:0];
    hsel_mask = HART_COUNT'(1) << hsel;
    acc_ok  = (item_q.access_size == clint_pkg::WORD_SIZE) &&
              (item_q.offset[1:0] == 2'b00) &&
              ((is_msip && (idx_s < live)) ||
               (is_cmp && (idx_c < live)) ||
               is_time);
    cmp_sel = cmp[hsel];
    if (is_msip) begin
      rdata = {31'd0, soft_bits[hsel]};
    end else if (is_cmp) begin
      rdata = hi ? cmp_sel[63:32] : cmp_sel[31:0];
    end else begin
      rdata = hi ? time_count[63:32] : time_count[31:0];
    end
  end

  always_comb begin
    for (int h = 0; h < HART_COUNT; h++) begin
      ge[h] = (time_count >= cmp[h]);
    end
    tnext    = (recmask & ge) | (~recmask & timer);
    wake_all = wake_q | (tnext & ~timer);
    tp_ext   = {4'd0, tnext};
    sp_ext   = {4'd0, soft_bits};
    wk_ext   = {4'd0, wake_all};
  end

  // state with reset
  always_ff @(posedge clk) begin
    if (rst) begin
      time_count     <= '0;
      soft_bits      <= '0;
      timer          <= '0;
      active_harts   <= 3'd1;
      tick_increment <= 32'd1;
      for (int h = 0; h < HART_COUNT; h++) begin
        cmp[h] <= '1;
      end
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          clint_pkg::REG_ACTIVE_HARTS:   active_harts <= cfg_data[2:0];
          clint_pkg::REG_TICK_INCREMENT: tick_increment <= cfg_data[31:0];
          default: ;
        endcase
      end
      if (ctl.exec) begin
        case (item_q.cmd)
          clint_pkg::CMD_WRITE: begin
            if (acc_ok) begin
              if (is_msip) begin
                soft_bits[hsel] <= item_q.write_data[0];
              end else if (is_cmp) begin
                if (hi) cmp[hsel][63:32] <= item_q.write_data;
                else    cmp[hsel][31:0]  <= item_q.write_data;
              end else begin
                if (hi) time_count[63:32] <= item_q.write_data;
                else    time_count[31:0]  <= item_q.write_data;
              end
            end
          end
          clint_pkg::CMD_TICK: time_count <= time_count + {32'd0, tick_increment};
          clint_pkg::CMD_RESET: begin
            soft_bits <= '0;
            timer     <= '0;
            for (int h = 0; h < HART_COUNT; h++) begin
              cmp[h] <= '1;
            end
          end
          default: ;
        endcase
      end
      if (ctl.eval) begin
        timer <= tnext;
      end
    end
  end

  // payload, no reset
  always_ff @(posedge clk) begin
    if (ctl.load) begin
      item_q <= item;
    end
    if (ctl.exec) begin
      rd_q    <= '0;
      fault_q <= clint_pkg::FAULT_NONE;
      recmask <= '0;
      wake_q  <= '0;
      case (item_q.cmd)
        clint_pkg::CMD_READ: begin
          if (acc_ok) rd_q <= rdata;
          else        fault_q <= clint_pkg::FAULT_LOAD;
        end
        clint_pkg::CMD_WRITE: begin
          if (!acc_ok) begin
            fault_q <= clint_pkg::FAULT_STORE;
          end else if (is_msip) begin
            wake_q <= hsel_mask;
          end else if (is_cmp) begin
            recmask <= hsel_mask;
          end else begin
            recmask <= live_mask;
          end
        end
        clint_pkg::CMD_TICK: recmask <= live_mask;
        default: ;
      endcase
    end
    if (ctl.eval) begin
      result.read_data     <= rd_q;
      result.fault_code    <= fault_q;
      result.timer_pending <= tp_ext[3:0];
      result.soft_pending  <= sp_ext[3:0];
      result.wake_mask     <= wk_ext[3:0];
    end
  end

endmodule

### hw/rtl/core_local_timer_interruptor.sv
// top level of the core-local timer interruptor (msip, mtimecmp, mtime)
`timescale 1ns / 1ps

// usage
//   command channel: drive item and raise start; the transaction is taken at
//   the rising edge where start is high and busy is low
//   result channel: done is high for exactly one cycle and result is valid then;
//   the receiver cannot stall, so it must sample result on that edge
//   config port: cfg_we with cfg_index (0 active_harts, 1 tick_increment) and
//   cfg_data; written at the edge, no read-back; write only while idle
//   the item is latched at the accepting edge, then the sequencer walks
//   execute and recompute timer bits; done and the result are registered at
//   the end of recompute; busy drops in the cycle done is high
//   a new transaction can be taken once busy is low, after the sequencer has
//   walked execute then the per-hart 64-bit mtime >= mtimecmp compare
//   every transaction returns exactly one result, faults included
//   reset (rst, synchronous): mtime zero, mtimecmp all ones, soft and timer
//   bits zero, active_harts 1, tick_increment 1, no result pending
module core_local_timer_interruptor #(
  parameter int HART_COUNT = 4
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             start,
  output logic                             busy,
  input  clint_pkg::in_t                   item,
  output logic                             done,
  output clint_pkg::out_t                  result,
  input  logic                             cfg_we,
  input  logic [clint_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [clint_pkg::CFG_DATA_W-1:0] cfg_data
);

  // sequencer commands into the datapath
  clint_pkg::ctl_t ctl;

  // control: idle, execute, recompute
  clint_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .done  (done),
    .ctl   (ctl)
  );

  // storage, address decode, compares, result register
  clint_dp #(
    .HART_COUNT (HART_COUNT)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .ctl       (ctl),
    .item      (item),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .result    (result)
  );

`ifndef NO_ASSERTIONS
  // a result only follows a transaction in flight
  a_done_after_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy))
    else $error("result strobe without a transaction in flight");

  // an accepted transaction makes the block busy
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("accepted transaction did not raise busy");

  // a faulting access returns zero data
  a_fault_zero: assert property (@(posedge clk) disable iff (rst)
    (done && (result.fault_code != clint_pkg::FAULT_NONE)) |-> (result.read_data == 32'd0))
    else $error("faulting access returned data");

  // no undefined fault code
  a_fault_code: assert property (@(posedge clk) disable iff (rst)
    done |-> (result.fault_code <= clint_pkg::FAULT_STORE))
    else $error("undefined fault code");
`endif

endmodule
